/* rtl/core/wtmf_pkg.sv */
package wtmf_pkg;

	// request codes
	typedef enum logic [1:0] {
		REQ_CHECK  = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_REMOVE = 2'd2
	} req_code_t;

	// result status codes
	typedef enum logic [2:0] {
		STAT_NO_HIT    = 3'd0,
		STAT_HIT       = 3'd1,
		STAT_IGNORED   = 3'd2,
		STAT_ADDED     = 3'd3,
		STAT_PRESENT   = 3'd4,
		STAT_FULL      = 3'd5,
		STAT_REMOVED   = 3'd6,
		STAT_NOT_FOUND = 3'd7
	} stat_code_t;

	// hit path codes
	localparam logic KIND_BEACON = 1'b0;
	localparam logic KIND_OTHER  = 1'b1;

	// frame header decode constants
	localparam logic [15:0] CHECK_LEN     = 16'd128;
	localparam logic [1:0]  FT_MGMT       = 2'd0;
	localparam logic [3:0]  SUB_BEACON    = 4'd8;
	localparam logic [3:0]  SUB_PROBE_RSP = 4'd5;
	localparam logic [1:0]  DS_FROM_AP    = 2'd2;
	localparam logic [1:0]  DS_WDS        = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [47:0]       target_mac;
		logic [15:0]       frame_length;
		logic [7:0]        frame_control;
		logic [7:0]        frame_flags;
		logic [47:0]       addr_one;
		logic [47:0]       addr_two;
		logic [47:0]       addr_three;
		logic signed [7:0] rssi;
		logic [3:0]        rx_channel;
	} wtmf_req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic              hit_kind;
		logic [47:0]       matched_mac;
		logic signed [7:0] rssi_out;
		logic [3:0]        channel_out;
	} wtmf_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic finish;
	} wtmf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} wtmf_sts_t;

endpackage

/* rtl/core/wtmf_ctrl.sv */
module wtmf_ctrl
	import wtmf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  wtmf_sts_t sts,
	output wtmf_cmd_t cmd,
	output logic      busy
);

	state_t state_q;
	state_t state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequence: load, scan every slot, drain the read stage, commit
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/wtmf_dpath.sv */
module wtmf_dpath
	import wtmf_pkg::*;
#(
	parameter int MAX_TARGETS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  wtmf_cmd_t cmd,
	input  wtmf_req_t req,
	output wtmf_sts_t sts,
	output wtmf_rsp_t rsp,
	output logic      done
);

	localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TARGETS - 1);

	// target table and per-slot valid bits
	logic [47:0]            mem_q [MAX_TARGETS];
	logic [MAX_TARGETS-1:0] valid_q;

	// latched request
	logic [1:0]        req_type_q;
	logic [47:0]       key_q;
	logic              kind_q;
	logic              len_ok_q;
	logic signed [7:0] rssi_q;
	logic [3:0]        chan_q;

	// scan state
	logic [IDX_W-1:0] idx_q;
	logic             act_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [47:0]      rd_s1;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	// commit decode
	logic [47:0] key_d;
	logic        kind_d;
	logic [1:0]  ftype;
	logic [3:0]  fsub;
	wtmf_rsp_t   rsp_d;
	wtmf_rsp_t   rsp_q;
	logic        done_q;
	logic        mem_we;
	logic        set_vld;
	logic        clr_vld;

	// select the address to look up
	always_comb begin
		ftype  = req.frame_control[3:2];
		fsub   = req.frame_control[7:4];
		key_d  = req.addr_two;
		kind_d = KIND_OTHER;
		if (req.req_type != REQ_CHECK) begin
			key_d = req.target_mac;
		end else if (ftype == FT_MGMT && (fsub == SUB_BEACON || fsub == SUB_PROBE_RSP)) begin
			kind_d = KIND_BEACON;
		end else begin
			case (req.frame_flags[1:0])
				DS_FROM_AP: key_d = req.addr_three;
				DS_WDS:     key_d = req.addr_one;
				default:    key_d = req.addr_two;
			endcase
		end
	end

	// latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req.req_type;
			key_q      <= key_d;
			kind_q     <= kind_d;
			len_ok_q   <= (req.frame_length == CHECK_LEN);
			rssi_q     <= req.rssi;
			chan_q     <= req.rx_channel;
		end
	end

	// table write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[free_idx_q] <= key_q;
		end
	end

	// table read port
	always_ff @(posedge clk) begin
		rd_s1  <= mem_q[idx_q];
		idx_s1 <= idx_q;
	end

	// advance the scan and track first match and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			act_s1  <= 1'b0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			act_s1 <= cmd.issue;
			vld_s1 <= valid_q[idx_q];
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (cmd.issue && idx_q != LAST_IDX) begin
					idx_q <= idx_q + 1'b1;
				end
				if (act_s1 && vld_s1 && rd_s1 == key_q && !found_q) begin
					found_q <= 1'b1;
				end
				if (act_s1 && !vld_s1 && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	// hold the slot numbers of the first match and first free slot
	always_ff @(posedge clk) begin
		if (act_s1 && vld_s1 && rd_s1 == key_q && !found_q) begin
			found_idx_q <= idx_s1;
		end
		if (act_s1 && !vld_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// decide the result and the table update
	always_comb begin
		rsp_d        = '0;
		rsp_d.status = STAT_IGNORED;
		set_vld      = 1'b0;
		clr_vld      = 1'b0;
		case (req_type_q)
			REQ_ADD: begin
				if (found_q) begin
					rsp_d.status = STAT_PRESENT;
				end else if (free_q) begin
					rsp_d.status = STAT_ADDED;
					set_vld      = 1'b1;
				end else begin
					rsp_d.status = STAT_FULL;
				end
			end
			REQ_REMOVE: begin
				if (found_q) begin
					rsp_d.status = STAT_REMOVED;
					clr_vld      = 1'b1;
				end else begin
					rsp_d.status = STAT_NOT_FOUND;
				end
			end
			REQ_CHECK: begin
				if (len_ok_q) begin
					if (found_q) begin
						rsp_d.status      = STAT_HIT;
						rsp_d.hit_kind    = kind_q;
						rsp_d.matched_mac = key_q;
						rsp_d.rssi_out    = rssi_q;
						rsp_d.channel_out = chan_q;
					end else begin
						rsp_d.status = STAT_NO_HIT;
					end
				end
			end
			default: ;
		endcase
	end

	assign mem_we = cmd.finish && set_vld;

	// update valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.finish) begin
			if (set_vld) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (clr_vld) begin
				valid_q[found_idx_q] <= 1'b0;
			end
		end
	end

	// register the result and its strobe
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign sts.scan_last = (idx_q == LAST_IDX);
	assign rsp           = rsp_q;
	assign done          = done_q;

endmodule

/* rtl/core/wifi_frame_target_mac_filter.sv */
// A request passes through an accept state, a table scan, a drain state and a commit state;
// the scan reads one slot per cycle through the single read port, and the result and its
// strobe are registered at the commit. The block takes no new request until the commit is
// done; a new request may start in the cycle its predecessor's result is shown.
// Reset (arst_n low) empties the table at once; the receiver cannot stall results.
module wifi_frame_target_mac_filter
	import wtmf_pkg::*;
#(
	parameter int MAX_TARGETS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  wtmf_req_t req,
	output logic      done,
	output wtmf_rsp_t rsp
);

	wtmf_cmd_t cmd;
	wtmf_sts_t sts;

	wtmf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	wtmf_dpath #(
		.MAX_TARGETS (MAX_TARGETS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.sts    (sts),
		.rsp    (rsp),
		.done   (done)
	);

endmodule

/* rtl/core/wtmf_chk.sv */
module wtmf_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// a started request keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start transfer");

	// each result shows for one cycle only
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// a result comes while the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// finishing a request always delivers its result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result");

endmodule

bind wifi_frame_target_mac_filter wtmf_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
